/* rtl/hrrn_pkg.sv */
// Package for the HRRN ready scheduler: operation and status codes,
// controller states, default sizes and small helper functions.
// No dependencies.
package hrrn_pkg;

    localparam int unsigned DEF_READY_DEPTH = 16;
    localparam int unsigned DEF_MAX_PIDS    = 64;

    localparam int unsigned PID_W  = 6;
    localparam int unsigned WAIT_W = 16;
    localparam int unsigned EST_W  = 24;
    localparam int unsigned ENT_W  = PID_W + WAIT_W;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    localparam logic [2:0] OP_ADMIT    = 3'd0;
    localparam logic [2:0] OP_READY    = 3'd1;
    localparam logic [2:0] OP_BURST    = 3'd2;
    localparam logic [2:0] OP_TICK     = 3'd3;
    localparam logic [2:0] OP_DISPATCH = 3'd4;
    localparam logic [2:0] OP_EXIT     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_INIT   = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;
    localparam logic [1:0] CFG_MAXACT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_BURST_MUL,
        S_BURST_WR,
        S_TICK,
        S_SC_RD,
        S_SC_EST,
        S_SC_CMP,
        S_SC_NEXT,
        S_SHIFT,
        S_DONE
    } t_state;

    function automatic logic [EST_W-1:0] clamp_est(input logic [EST_W-1:0] e);
        clamp_est = (e == '0) ? EST_W'(1) : e;
    endfunction

    // pid modulo table size, restoring subtraction over six steps
    function automatic logic [7:0] est_slot(input logic [PID_W-1:0] pid,
                                            input int unsigned m);
        logic [PID_W:0] rem;
        rem = {1'b0, pid};
        for (int k = 5; k >= 0; k--) begin
            if ((m << k) <= 63 && 32'(rem) >= (m << k)) begin
                rem = rem - (PID_W+1)'(m << k);
            end
        end
        est_slot = 8'(rem);
    endfunction

endpackage

/* rtl/hrrn_ready_scheduler_top.sv */
// HRRN ready scheduler: ready table and burst-estimate table in block RAM,
// with a sequencer that reads, updates and writes back. Uses hrrn_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: operation,
//   pid and burst time. Output channel (o_out_valid / i_out_stall) returns
//   exactly one result item per input item, in order.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
//   policy, initial estimate, alpha and active limit; the user must write
//   them only while idle; the block does not enforce this. Burst end goes
//   through S_BURST_MUL and S_BURST_WR, tick through S_TICK once per ready
//   entry. Dispatch walks the ready table one entry at a time through the
//   two RAM reads and the ratio multipliers (all n entries in HRRN mode,
//   one in FIFO mode), then shifts each entry behind the removed one down.
//   One item is in work at a time. A finished result waits in the output
//   register while the next item is taken; if the receiver stalls, the
//   sequencer holds in its final state.
//   Reset empties the ready table, clears the active count and loads the
//   register defaults; the estimate table is not cleared.
module hrrn_ready_scheduler_top #(
    parameter int unsigned READY_DEPTH = hrrn_pkg::DEF_READY_DEPTH,
    parameter int unsigned MAX_PIDS    = hrrn_pkg::DEF_MAX_PIDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_pid,
    input  logic [15:0] i_burst_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_chosen_pid,
    output logic        o_chosen_valid,
    output logic [1:0]  o_status,
    output logic [23:0] o_estimate_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import hrrn_pkg::*;

    localparam int RA = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int CW = $clog2(READY_DEPTH + 1);
    localparam int EA = (MAX_PIDS > 1) ? $clog2(MAX_PIDS) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(READY_DEPTH);

    t_state r_state, n_state;

    logic [2:0]        r_op, n_op;
    logic [PID_W-1:0]  r_pid, n_pid;
    logic [WAIT_W-1:0] r_burst, n_burst;

    logic              r_policy;
    logic [EST_W-1:0]  r_init;
    logic [8:0]        r_alpha;
    logic [6:0]        r_max;

    logic [6:0]        r_active, n_active;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_lim, n_lim;

    logic [PID_W-1:0]  r_cpid, n_cpid;
    logic [WAIT_W-1:0] r_cwait, n_cwait;
    logic [24:0]       r_cnum, n_cnum;
    logic [EST_W-1:0]  r_cest, n_cest;
    logic [EST_W-1:0]  r_craw, n_craw;

    logic [CW-1:0]     r_bidx, n_bidx;
    logic [PID_W-1:0]  r_bpid, n_bpid;
    logic [24:0]       r_bnum, n_bnum;
    logic [EST_W-1:0]  r_best, n_best;
    logic [EST_W-1:0]  r_braw, n_braw;

    logic [48:0]       r_m1, n_m1, r_m2, n_m2;
    logic [32:0]       r_p1, n_p1, r_p2, n_p2;

    logic [PID_W-1:0]  r_res_pid, n_res_pid;
    logic              r_res_val, n_res_val;
    logic [1:0]        r_res_st, n_res_st;
    logic [EST_W-1:0]  r_res_est, n_res_est;

    logic              r_out_valid, n_out_valid;
    logic [PID_W-1:0]  r_o_pid, n_o_pid;
    logic              r_o_val, n_o_val;
    logic [1:0]        r_o_st, n_o_st;
    logic [EST_W-1:0]  r_o_est, n_o_est;

    logic [ENT_W-1:0]  r_rdy_mem [READY_DEPTH];
    logic [ENT_W-1:0]  r_rdy_q;
    logic              w_rdy_we;
    logic [RA-1:0]     w_rdy_wa, w_rdy_ra;
    logic [ENT_W-1:0]  w_rdy_wd;

    logic [EST_W-1:0]  r_est_mem [MAX_PIDS];
    logic [EST_W-1:0]  r_est_q;
    logic              w_est_we;
    logic [EA-1:0]     w_est_wa, w_est_ra;
    logic [EST_W-1:0]  w_est_wd;

    logic [7:0]        w_slot_full, w_cslot_full;
    logic [EA-1:0]     w_slot, w_cslot;
    logic [8:0]        w_a;
    logic [33:0]       w_sum;
    logic [25:0]       w_shr;
    logic [EST_W-1:0]  w_newest;
    logic [EST_W-1:0]  w_ec;
    logic [24:0]       w_num;
    logic [WAIT_W-1:0] w_wait;

    always_ff @(posedge i_clk) begin
        if (w_rdy_we) begin
            r_rdy_mem[w_rdy_wa] <= w_rdy_wd;
        end
        r_rdy_q <= r_rdy_mem[w_rdy_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_est_we) begin
            r_est_mem[w_est_wa] <= w_est_wd;
        end
        r_est_q <= r_est_mem[w_est_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b1;
            r_init   <= 24'd2560;
            r_alpha  <= 9'd128;
            r_max    <= 7'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLICY: r_policy <= i_cfg_data[0];
                CFG_INIT:   r_init   <= i_cfg_data;
                CFG_ALPHA:  r_alpha  <= i_cfg_data[8:0];
                CFG_MAXACT: r_max    <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pid     <= n_pid;
        r_burst   <= n_burst;
        r_i       <= n_i;
        r_lim     <= n_lim;
        r_cpid    <= n_cpid;
        r_cwait   <= n_cwait;
        r_cnum    <= n_cnum;
        r_cest    <= n_cest;
        r_craw    <= n_craw;
        r_bidx    <= n_bidx;
        r_bpid    <= n_bpid;
        r_bnum    <= n_bnum;
        r_best    <= n_best;
        r_braw    <= n_braw;
        r_m1      <= n_m1;
        r_m2      <= n_m2;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_res_pid <= n_res_pid;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_res_est <= n_res_est;
        r_o_pid   <= n_o_pid;
        r_o_val   <= n_o_val;
        r_o_st    <= n_o_st;
        r_o_est   <= n_o_est;
    end

    assign w_slot_full  = est_slot(r_pid, MAX_PIDS);
    assign w_cslot_full = est_slot(r_rdy_q[ENT_W-1:WAIT_W], MAX_PIDS);
    assign w_slot       = w_slot_full[EA-1:0];
    assign w_cslot      = w_cslot_full[EA-1:0];
    assign w_a      = (r_alpha > 9'd256) ? 9'd256 : r_alpha;
    assign w_sum    = 34'(r_p1) + 34'(r_p2);
    assign w_shr    = w_sum[33:8];
    assign w_newest = (w_shr == '0) ? EST_W'(1) : w_shr[EST_W-1:0];
    assign w_ec     = clamp_est(r_est_q);
    assign w_num    = 25'({r_cwait, 8'h00}) + 25'(w_ec);
    assign w_wait   = r_rdy_q[WAIT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pid       = r_pid;
        n_burst     = r_burst;
        n_active    = r_active;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_lim       = r_lim;
        n_cpid      = r_cpid;
        n_cwait     = r_cwait;
        n_cnum      = r_cnum;
        n_cest      = r_cest;
        n_craw      = r_craw;
        n_bidx      = r_bidx;
        n_bpid      = r_bpid;
        n_bnum      = r_bnum;
        n_best      = r_best;
        n_braw      = r_braw;
        n_m1        = r_m1;
        n_m2        = r_m2;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_res_pid   = r_res_pid;
        n_res_val   = r_res_val;
        n_res_st    = r_res_st;
        n_res_est   = r_res_est;
        n_out_valid = r_out_valid;
        n_o_pid     = r_o_pid;
        n_o_val     = r_o_val;
        n_o_st      = r_o_st;
        n_o_est     = r_o_est;
        w_rdy_we    = 1'b0;
        w_rdy_wa    = r_cnt[RA-1:0];
        w_rdy_wd    = {r_pid, {WAIT_W{1'b0}}};
        w_rdy_ra    = '0;
        w_est_we    = 1'b0;
        w_est_wa    = w_slot;
        w_est_wd    = clamp_est(r_init);
        w_est_ra    = w_slot;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_operation;
                    n_pid     = i_pid;
                    n_burst   = i_burst_time;
                    n_res_pid = '0;
                    n_res_val = 1'b0;
                    n_res_st  = ST_OK;
                    n_res_est = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_ADMIT: begin
                        if (r_active >= r_max) begin
                            n_res_st = ST_LIMIT;
                        end else if (r_cnt == DEPTH_C) begin
                            n_res_st = ST_FULL;
                        end else begin
                            w_est_we = 1'b1;
                            w_rdy_we = 1'b1;
                            n_cnt    = r_cnt + 1'b1;
                            n_active = r_active + 1'b1;
                        end
                    end
                    OP_READY: begin
                        if (r_cnt == DEPTH_C) begin
                            n_res_st = ST_FULL;
                        end else begin
                            w_rdy_we = 1'b1;
                            n_cnt    = r_cnt + 1'b1;
                        end
                    end
                    OP_BURST: begin
                        n_state = S_BURST_MUL;
                    end
                    OP_TICK: begin
                        n_i = '0;
                        if (r_cnt != '0) begin
                            n_state = S_TICK;
                        end
                    end
                    OP_DISPATCH: begin
                        n_i   = '0;
                        n_lim = r_policy ? r_cnt : CW'(1);
                        if (r_cnt == '0) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            n_state = S_SC_RD;
                        end
                    end
                    OP_EXIT: begin
                        if (r_active != '0) begin
                            n_active = r_active - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_BURST_MUL: begin
                n_p1    = 33'(w_a) * 33'({r_burst, 8'h00});
                n_p2    = 33'(9'd256 - w_a) * 33'(r_est_q);
                n_state = S_BURST_WR;
            end
            S_BURST_WR: begin
                w_est_we  = 1'b1;
                w_est_wd  = w_newest;
                n_res_est = w_newest;
                n_state   = S_DONE;
            end
            S_TICK: begin
                w_rdy_we = 1'b1;
                w_rdy_wa = r_i[RA-1:0];
                w_rdy_wd = {r_rdy_q[ENT_W-1:WAIT_W],
                            (w_wait == WAIT_MAX) ? w_wait : w_wait + 1'b1};
                if (r_i + 1'b1 < r_cnt) begin
                    w_rdy_ra = RA'(r_i + 1'b1);
                    n_i      = r_i + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SC_RD: begin
                n_cpid   = r_rdy_q[ENT_W-1:WAIT_W];
                n_cwait  = w_wait;
                w_est_ra = w_cslot;
                n_state  = S_SC_EST;
            end
            S_SC_EST: begin
                n_cnum = w_num;
                n_cest = w_ec;
                n_craw = r_est_q;
                n_m1   = 49'(w_num) * 49'(r_best);
                n_m2   = 49'(r_bnum) * 49'(w_ec);
                if (r_i == '0) begin
                    n_bidx  = r_i;
                    n_bpid  = r_cpid;
                    n_bnum  = w_num;
                    n_best  = w_ec;
                    n_braw  = r_est_q;
                    n_state = S_SC_NEXT;
                end else begin
                    n_state = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                if (r_m1 > r_m2) begin
                    n_bidx = r_i;
                    n_bpid = r_cpid;
                    n_bnum = r_cnum;
                    n_best = r_cest;
                    n_braw = r_craw;
                end
                n_state = S_SC_NEXT;
            end
            S_SC_NEXT: begin
                if (r_i + 1'b1 < r_lim) begin
                    w_rdy_ra = RA'(r_i + 1'b1);
                    n_i      = r_i + 1'b1;
                    n_state  = S_SC_RD;
                end else begin
                    n_res_pid = r_bpid;
                    n_res_val = 1'b1;
                    n_res_est = r_braw;
                    if (r_bidx + 1'b1 < r_cnt) begin
                        w_rdy_ra = RA'(r_bidx + 1'b1);
                        n_i      = r_bidx + 1'b1;
                        n_state  = S_SHIFT;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                w_rdy_we = 1'b1;
                w_rdy_wa = RA'(r_i - 1'b1);
                w_rdy_wd = r_rdy_q;
                if (r_i + 1'b1 < r_cnt) begin
                    w_rdy_ra = RA'(r_i + 1'b1);
                    n_i      = r_i + 1'b1;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_pid     = r_res_pid;
                    n_o_val     = r_res_val;
                    n_o_st      = r_res_st;
                    n_o_est     = r_res_est;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_chosen_pid   = r_o_pid;
    assign o_chosen_valid = r_o_val;
    assign o_status       = r_o_st;
    assign o_estimate_out = r_o_est;
    assign o_cfg_ready    = 1'b1;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("ready count beyond table depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_i < r_cnt && r_i != '0))
        else $error("shift index out of range");

    a_chosen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_chosen_valid) |-> (o_status == ST_OK))
        else $error("dispatch result with bad status");
`endif

endmodule
